// File: rtl/core/aus_pkg.sv
// ----------------------------------------------------------------------------
// aus_pkg
// Shared types and constants for the Annex B access unit splitter.
// ----------------------------------------------------------------------------
package aus_pkg;

  localparam int unsigned OFFSET_WIDTH = 32;

  localparam logic [OFFSET_WIDTH-1:0] POS_MAX = {OFFSET_WIDTH{1'b1}};

  localparam logic [4:0]  NAL_TYPE_MASK    = 5'h1f;
  localparam logic [4:0]  NAL_TYPE_AUD     = 5'd9;
  localparam logic [31:0] DEFAULT_DURATION = 32'd333333;

  localparam logic KIND_FRAME = 1'b0;
  localparam logic KIND_ERROR = 1'b1;

  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);

  typedef struct packed {
    logic        result_kind;
    logic [31:0] frame_offset;
    logic [31:0] frame_size;
    logic [31:0] frame_index;
    logic [63:0] frame_time;
    logic        last_result;
  } result_t;

  // up to two results written per transfer, in order
  typedef struct packed {
    logic    push0;
    logic    push1;
    result_t res0;
    result_t res1;
  } push_t;

endpackage

// File: rtl/core/aus_in_if.sv
// ----------------------------------------------------------------------------
// aus_in_if
// Byte stream channel: valid/ready with one stream byte and end marker.
// ----------------------------------------------------------------------------
interface aus_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_stream;

  modport source (output valid, output data_byte, output end_of_stream, input ready);
  modport sink   (input valid, input data_byte, input end_of_stream, output ready);
endinterface

// File: rtl/core/aus_out_if.sv
// ----------------------------------------------------------------------------
// aus_out_if
// Result channel: valid/ready with one frame record or error per transfer.
// ----------------------------------------------------------------------------
interface aus_out_if;
  logic        valid;
  logic        ready;
  logic        result_kind;
  logic [31:0] frame_offset;
  logic [31:0] frame_size;
  logic [31:0] frame_index;
  logic [63:0] frame_time;
  logic        last_result;

  modport source (output valid, output result_kind, output frame_offset, output frame_size,
                  output frame_index, output frame_time, output last_result, input ready);
  modport sink   (input valid, input result_kind, input frame_offset, input frame_size,
                  input frame_index, input frame_time, input last_result, output ready);
endinterface

// File: rtl/core/aus_result_fifo.sv
// ----------------------------------------------------------------------------
// aus_result_fifo
// Four-entry result queue: takes up to two results per cycle, drains one.
// ----------------------------------------------------------------------------
module aus_result_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  aus_pkg::push_t push,
  output logic           has_room,
  aus_out_if.source      out_ch
);
  import aus_pkg::*;

  result_t                mem_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [FIFO_AW-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [FIFO_AW:0]       count_r, count_nxt;
  logic                   pop;
  logic [FIFO_AW-1:0]     wr_ptr_p1;
  logic [FIFO_AW:0]       n_push;
  result_t                head;

  // room for a worst-case pair of results
  assign has_room  = count_r <= (FIFO_AW+1)'(FIFO_DEPTH - 2);
  assign pop       = out_ch.valid && out_ch.ready;
  assign wr_ptr_p1 = wr_ptr_r + 1'b1;
  assign n_push    = (FIFO_AW+1)'(push.push0) + (FIFO_AW+1)'(push.push1);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + n_push[FIFO_AW-1:0];
    rd_ptr_nxt = rd_ptr_r + FIFO_AW'(pop);
    count_nxt  = count_r + n_push - (FIFO_AW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.push0) begin
      mem_r[wr_ptr_r] <= push.res0;
    end
    if (push.push1) begin
      mem_r[wr_ptr_p1] <= push.res1;
    end
  end

  assign head                = mem_r[rd_ptr_r];
  assign out_ch.valid        = count_r != '0;
  assign out_ch.result_kind  = head.result_kind;
  assign out_ch.frame_offset = head.frame_offset;
  assign out_ch.frame_size   = head.frame_size;
  assign out_ch.frame_index  = head.frame_index;
  assign out_ch.frame_time   = head.frame_time;
  assign out_ch.last_result  = head.last_result;

endmodule

// File: rtl/core/annexb_access_unit_splitter.sv
// ----------------------------------------------------------------------------
// annexb_access_unit_splitter
// Splits an H.264 Annex B byte stream into access units at AUD start codes.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch   one stream byte per transfer, end_of_stream on the final byte.
//   out_ch  frame records (offset, size, index, time) and truncated start
//           code errors; last_result marks the final result of a byte.
//   cfg_we/cfg_wdata  sets frame_duration; write only while idle.
// Throughput is one byte per clock while in_ch.ready is high. The scanner
// state updates in the cycle of the transfer and its results land in a
// four-entry result queue, which offers them on out_ch in order.
// A byte yields at most two results; each takes one out_ch transfer.
// in_ch.ready drops while the queue has fewer than two free entries, so a
// stalled receiver backs up into the byte stream after at most four results.
// Reset clears the scanner, the frame count, the time and the queue, and
// loads frame_duration with 333333. The final byte of a stream also returns
// the scanner to its reset state, keeping frame_duration.
// ----------------------------------------------------------------------------
module annexb_access_unit_splitter (
  input  logic        clk,
  input  logic        rst_n,
  aus_in_if.sink      in_ch,
  aus_out_if.source   out_ch,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata
);
  import aus_pkg::*;

  logic [31:0]             duration_r;
  logic [OFFSET_WIDTH-1:0] pos_r, pos_nxt;
  logic [1:0]              zrun_r, zrun_nxt;
  logic                    hdr_r, hdr_nxt;
  logic [OFFSET_WIDTH-1:0] code_pos_r, code_pos_nxt;
  logic                    open_r, open_nxt;
  logic [OFFSET_WIDTH-1:0] start_r, start_nxt;
  logic [31:0]             count_r, count_nxt;
  logic [63:0]             time_r, time_nxt;

  logic                    accept;
  logic                    has_room;
  logic                    is_aud;
  logic                    new_hdr;
  logic [OFFSET_WIDTH-1:0] new_code_pos;
  logic [OFFSET_WIDTH-1:0] size1, size2;
  logic [OFFSET_WIDTH-1:0] start_mid;
  logic                    open_mid;
  logic [31:0]             count_mid;
  logic [63:0]             time_plus, time_mid;
  logic                    emit1, emit2, err;
  result_t                 res1, res2, res_err;
  push_t                   push;

  assign accept      = in_ch.valid && in_ch.ready;
  assign in_ch.ready = has_room;

  always_comb begin
    is_aud       = (in_ch.data_byte[4:0] & NAL_TYPE_MASK) == NAL_TYPE_AUD;
    new_hdr      = (in_ch.data_byte == 8'h01) && (zrun_r >= 2'd2);
    new_code_pos = pos_r - ((zrun_r == 2'd3) ? OFFSET_WIDTH'(3) : OFFSET_WIDTH'(2));
    pos_nxt      = (pos_r < POS_MAX) ? pos_r + 1'b1 : pos_r;

    // AUD start code closes the open frame
    size1     = code_pos_r - start_r;
    emit1     = hdr_r && open_r && is_aud && (size1 != '0);
    start_mid = (hdr_r && (!open_r || is_aud)) ? code_pos_r : start_r;
    open_mid  = open_r || hdr_r;
    time_plus = time_r + {32'd0, duration_r};
    count_mid = emit1 ? count_r + 1'b1 : count_r;
    time_mid  = emit1 ? time_plus : time_r;

    // end of stream flush, then a dangling start code is an error
    size2 = pos_nxt - start_mid;
    emit2 = in_ch.end_of_stream && open_mid && (size2 != '0);
    err   = in_ch.end_of_stream && new_hdr;

    res1 = '{result_kind: KIND_FRAME, frame_offset: 32'(start_r), frame_size: 32'(size1),
             frame_index: count_r, frame_time: time_r, last_result: 1'b0};
    res2 = '{result_kind: KIND_FRAME, frame_offset: 32'(start_mid), frame_size: 32'(size2),
             frame_index: count_mid, frame_time: time_mid, last_result: 1'b0};
    res_err = '{result_kind: KIND_ERROR, frame_offset: '0, frame_size: '0,
                frame_index: '0, frame_time: '0, last_result: 1'b1};

    push.push0 = accept && (emit1 || emit2 || err);
    push.push1 = accept && ((emit1 && emit2) || (emit2 && err) || (emit1 && err));
    push.res0  = emit1 ? res1 : (emit2 ? res2 : res_err);
    push.res1  = (emit1 && emit2) ? res2 : res_err;
    push.res0.last_result = !push.push1;
    push.res1.last_result = 1'b1;

    zrun_nxt     = (in_ch.data_byte == 8'h00) ? ((zrun_r == 2'd3) ? zrun_r : zrun_r + 1'b1)
                                              : 2'd0;
    hdr_nxt      = new_hdr;
    code_pos_nxt = new_hdr ? new_code_pos : code_pos_r;
    open_nxt     = open_mid;
    start_nxt    = start_mid;
    count_nxt    = count_mid;
    time_nxt     = time_mid;
  end

  aus_result_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .has_room (has_room),
    .out_ch   (out_ch)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      duration_r <= DEFAULT_DURATION;
      pos_r      <= '0;
      zrun_r     <= '0;
      hdr_r      <= 1'b0;
      code_pos_r <= '0;
      open_r     <= 1'b0;
      start_r    <= '0;
      count_r    <= '0;
      time_r     <= '0;
    end else begin
      if (cfg_we) begin
        duration_r <= cfg_wdata;
      end
      if (accept) begin
        if (in_ch.end_of_stream) begin
          pos_r      <= '0;
          zrun_r     <= '0;
          hdr_r      <= 1'b0;
          code_pos_r <= '0;
          open_r     <= 1'b0;
          start_r    <= '0;
          count_r    <= '0;
          time_r     <= '0;
        end else begin
          pos_r      <= pos_nxt;
          zrun_r     <= zrun_nxt;
          hdr_r      <= hdr_nxt;
          code_pos_r <= code_pos_nxt;
          open_r     <= open_nxt;
          start_r    <= start_nxt;
          count_r    <= count_nxt;
          time_r     <= time_nxt;
        end
      end
    end
  end

endmodule

// File: rtl/core/aus_checker.sv
// ----------------------------------------------------------------------------
// aus_checker
// Port-level checks on the splitter's result channel, bound to the top level.
// ----------------------------------------------------------------------------
module aus_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic        result_kind,
  input logic [31:0] frame_offset,
  input logic [31:0] frame_size,
  input logic [31:0] frame_index,
  input logic [63:0] frame_time,
  input logic        last_result
);
  import aus_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(frame_offset) && $stable(frame_size)
      && $stable(frame_index) && $stable(frame_time) && $stable(result_kind))
    else $error("result changed while stalled");

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result offered right after reset");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && result_kind == KIND_ERROR |-> frame_offset == '0 && frame_size == '0
      && frame_index == '0 && frame_time == '0 && last_result)
    else $error("error result carries data or is not last");

  a_frame_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && result_kind == KIND_FRAME |-> frame_size != '0)
    else $error("empty frame reported");

endmodule

bind annexb_access_unit_splitter aus_checker u_aus_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .result_kind  (out_ch.result_kind),
  .frame_offset (out_ch.frame_offset),
  .frame_size   (out_ch.frame_size),
  .frame_index  (out_ch.frame_index),
  .frame_time   (out_ch.frame_time),
  .last_result  (out_ch.last_result)
);
